@@ sv/cfe_pkg.sv @@
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and constants for the COBS frame encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int unsigned DEF_MAX_MESSAGE = 1024;
    localparam int unsigned ADDR_W          = 11;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned FIFO_DEPTH      = 4;
    localparam int unsigned IN_DATA_W       = 8;
    localparam int unsigned OUT_DATA_W      = 32;

    localparam logic [BYTE_W-1:0] FULL_CODE = 8'hff;
    localparam logic [BYTE_W-1:0] FIRST_CODE = 8'h01;

    // One accepted item, classified: up to three writes in this order.
    typedef struct packed {
        logic              a_v;      // data byte write
        logic [ADDR_W-1:0] a_addr;
        logic [BYTE_W-1:0] a_byte;
        logic              b_v;      // code byte write-back (zero or full run)
        logic [ADDR_W-1:0] b_addr;
        logic [BYTE_W-1:0] b_code;
        logic              c_v;      // final write of the message
        logic [ADDR_W-1:0] c_addr;
        logic [BYTE_W-1:0] c_code;
        logic [ADDR_W-1:0] c_len;
        logic              c_ovf;
    } cmd_t;

    // One write request on the output side.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wbyte;
        logic              done;
        logic [ADDR_W-1:0] len;
        logic              ovf;
    } wr_t;

endpackage

@@ sv/cobs_frame_encoder.sv @@
// An item's first write request is registered in the command queue and then in
// the output stage before it is offered as valid.
// One item per cycle in while the command queue is not full; one write request
// per cycle out while the sink is ready. Items that cause two or three writes
// hold the back end until all are issued; a four-entry command queue absorbs the difference.
// Reset (rst_n low, asynchronous) clears block state, queue and output valid.
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// COBS encoder that turns a byte stream into buffer write requests.
// ----------------------------------------------------------------------------
module cobs_frame_encoder #(
    parameter int unsigned MAX_MESSAGE = cfe_pkg::DEF_MAX_MESSAGE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfe_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] has_byte
    input  logic                              s_tlast,   // last
    // write request stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfe_pkg::OUT_DATA_W-1:0]    m_tdata,   // [10:0] write_addr,
                                                          // [18:11] write_byte,
                                                          // [29:19] encoded_length,
                                                          // [30] overflow, [31] zero
    output logic                              m_tlast    // frame_done
);
    import cfe_pkg::*;

    logic accept;
    logic push;
    cmd_t cmd;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head;
    wr_t  req;

    // Front stalls only when the command queue is full.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    cfe_front #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .has_byte  (s_tuser),
        .data_byte (s_tdata[7:0]),
        .last      (s_tlast),
        .push      (push),
        .cmd       (cmd)
    );

    cfe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_req     (req)
    );

    assign m_tdata = {1'b0, req.ovf, req.len, req.wbyte, req.addr};
    assign m_tlast = req.done;

endmodule

@@ sv/cfe_front.sv @@
// ----------------------------------------------------------------------------
// cfe_front
// Accepts raw bytes, tracks the COBS block state and emits one command
// per item that needs any writes.
// ----------------------------------------------------------------------------
module cfe_front #(
    parameter int unsigned MAX_MESSAGE = cfe_pkg::DEF_MAX_MESSAGE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                has_byte,
    input  logic [7:0]          data_byte,
    input  logic                last,
    output logic                push,
    output cfe_pkg::cmd_t       cmd
);
    import cfe_pkg::*;

    localparam int unsigned BT_W    = $clog2(MAX_MESSAGE + 1);
    localparam int unsigned POS_RAW = $clog2(MAX_MESSAGE + MAX_MESSAGE / 254 + 3);
    // never narrower than the write address
    localparam int unsigned POS_W   = (POS_RAW > ADDR_W) ? POS_RAW : ADDR_W;

    logic [POS_W-1:0]  next_pos_reg,    next_pos_next;
    logic [POS_W-1:0]  code_slot_reg,   code_slot_next;
    logic [BYTE_W-1:0] run_code_reg,    run_code_next;
    logic [BT_W-1:0]   bytes_taken_reg, bytes_taken_next;
    logic              dropped_reg,     dropped_next;

    always_comb
    begin
        next_pos_next    = next_pos_reg;
        code_slot_next   = code_slot_reg;
        run_code_next    = run_code_reg;
        bytes_taken_next = bytes_taken_reg;
        dropped_next     = dropped_reg;
        cmd              = '0;

        if (has_byte)
        begin
            if (bytes_taken_reg < BT_W'(MAX_MESSAGE))
            begin
                bytes_taken_next = bytes_taken_reg + BT_W'(1);
                if (data_byte == '0)
                begin
                    // zero ends the block: write back its code
                    cmd.b_v        = 1'b1;
                    cmd.b_addr     = code_slot_reg[ADDR_W-1:0];
                    cmd.b_code     = run_code_reg;
                    code_slot_next = next_pos_reg;
                    next_pos_next  = next_pos_reg + POS_W'(1);
                    run_code_next  = FIRST_CODE;
                end
                else
                begin
                    cmd.a_v       = 1'b1;
                    cmd.a_addr    = next_pos_reg[ADDR_W-1:0];
                    cmd.a_byte    = data_byte;
                    next_pos_next = next_pos_reg + POS_W'(1);
                    run_code_next = run_code_reg + BYTE_W'(1);
                    if (run_code_next == FULL_CODE)
                    begin
                        // run of 254 bytes: close with code 0xff
                        cmd.b_v        = 1'b1;
                        cmd.b_addr     = code_slot_reg[ADDR_W-1:0];
                        cmd.b_code     = FULL_CODE;
                        code_slot_next = next_pos_next;
                        next_pos_next  = next_pos_reg + POS_W'(2);
                        run_code_next  = FIRST_CODE;
                    end
                end
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (last || !has_byte)
        begin
            cmd.c_v    = 1'b1;
            cmd.c_addr = code_slot_next[ADDR_W-1:0];
            cmd.c_code = run_code_next;
            cmd.c_len  = next_pos_next[ADDR_W-1:0];
            cmd.c_ovf  = dropped_next;

            next_pos_next    = POS_W'(1);
            code_slot_next   = '0;
            run_code_next    = FIRST_CODE;
            bytes_taken_next = '0;
            dropped_next     = 1'b0;
        end
    end

    assign push = accept && (cmd.a_v || cmd.b_v || cmd.c_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_pos_reg    <= POS_W'(1);
            code_slot_reg   <= '0;
            run_code_reg    <= FIRST_CODE;
            bytes_taken_reg <= '0;
            dropped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            next_pos_reg    <= next_pos_next;
            code_slot_reg   <= code_slot_next;
            run_code_reg    <= run_code_next;
            bytes_taken_reg <= bytes_taken_next;
            dropped_reg     <= dropped_next;
        end
    end

endmodule

@@ sv/cfe_fifo.sv @@
// ----------------------------------------------------------------------------
// cfe_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module cfe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cfe_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cfe_pkg::cmd_t  head
);
    import cfe_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/cfe_back.sv @@
// ----------------------------------------------------------------------------
// cfe_back
// Expands each queued command into one to three write requests, issued one
// per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module cfe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  cfe_pkg::cmd_t  q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output cfe_pkg::wr_t   out_req
);
    import cfe_pkg::*;

    cmd_t       cur_reg,   cur_next;
    logic [2:0] pend_reg,  pend_next;
    logic       valid_reg, valid_next;
    wr_t        out_reg,   out_next;

    cmd_t       src;
    logic [2:0] src_pend;
    logic [2:0] rem;
    logic       from_q;
    logic       load;
    wr_t        pick;

    always_comb
    begin
        from_q   = (pend_reg == '0);
        src      = from_q ? q_head : cur_reg;
        src_pend = from_q ? ({q_head.c_v, q_head.b_v, q_head.a_v} & {3{q_not_empty}})
                          : pend_reg;
        load     = (src_pend != '0) && (!valid_reg || out_ready);
        q_pop    = load && from_q;

        // oldest pending write first: data, code write-back, final
        pick = '0;
        rem  = src_pend;
        if (src_pend[0])
        begin
            pick.addr  = src.a_addr;
            pick.wbyte = src.a_byte;
            rem[0]     = 1'b0;
        end
        else if (src_pend[1])
        begin
            pick.addr  = src.b_addr;
            pick.wbyte = src.b_code;
            rem[1]     = 1'b0;
        end
        else
        begin
            pick.addr  = src.c_addr;
            pick.wbyte = src.c_code;
            pick.done  = 1'b1;
            pick.len   = src.c_len;
            pick.ovf   = src.c_ovf;
            rem[2]     = 1'b0;
        end

        cur_next   = cur_reg;
        pend_next  = pend_reg;
        out_next   = out_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            cur_next   = src;
            pend_next  = rem;
            out_next   = pick;
            valid_next = 1'b1;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = out_reg;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ bench/cobs_frame_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// cobs_frame_encoder_tb
// Self-checking bench: streams raw message bytes into the encoder and checks
// every buffer write request against a cycle-free COBS predictor.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_tb;

    import cfe_pkg::*;

    localparam int unsigned MAX_MESSAGE = DEF_MAX_MESSAGE;

    // How a generated message is closed.
    typedef enum logic {
        END_ON_LAST,    // tlast on the final data byte
        END_ON_MARKER   // extra request with has_byte low
    } msg_end_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // [7:0] data_byte
    logic                  s_tuser;     // [0] has_byte
    logic                  s_tlast;     // last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // [10:0] addr, [18:11] byte, [29:19] len,
                                        // [30] overflow, [31] zero
    logic                  m_tlast;     // frame_done

    cobs_frame_encoder #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predicted write requests, oldest first.
    wr_t pending_writes[$];

    // Encoder state as the predictor sees it; kept wide, masked on output.
    int unsigned enc_next_pos  = 1;
    int unsigned enc_code_slot = 0;
    int unsigned enc_run_code  = 1;
    int unsigned enc_taken     = 0;
    logic        enc_dropped   = 1'b0;

    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;
    int unsigned burst_left    = 0;
    // Set by a test to ask the sink for a long hold-off of this many cycles.
    int unsigned sink_hold_len = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Far above the slowest legal run (every request waiting out the sink).
    initial
    begin
        #2000000;
        $display("cobs_frame_encoder: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void expect_write(input int unsigned addr, input int unsigned code,
                                         input logic done, input int unsigned len,
                                         input logic ovf);
        wr_t w;
        w.addr  = ADDR_W'(addr);
        w.wbyte = BYTE_W'(code);
        w.done  = done;
        w.len   = ADDR_W'(len);
        w.ovf   = ovf;
        pending_writes.push_back(w);
    endfunction

    // Write back the open block's code byte and reserve a slot for the next.
    function automatic void close_run(input int unsigned code);
        expect_write(enc_code_slot, code, 1'b0, 0, 1'b0);
        enc_run_code  = 1;
        enc_code_slot = enc_next_pos;
        enc_next_pos++;
    endfunction

    function automatic void encode_item(input logic has, input logic [7:0] dbyte,
                                        input logic lst);
        if (has)
        begin
            if (enc_taken < MAX_MESSAGE)
            begin
                enc_taken++;
                if (dbyte == 8'h00)
                    close_run(enc_run_code);
                else
                begin
                    expect_write(enc_next_pos, dbyte, 1'b0, 0, 1'b0);
                    enc_next_pos++;
                    enc_run_code++;
                    // 254 data bytes in a block: code 0xff goes out at once
                    if (enc_run_code == FULL_CODE)
                        close_run(FULL_CODE);
                end
            end
            else
                enc_dropped = 1'b1;   // beyond the size limit: no write
        end
        // A request without a byte always ends the message.
        if (lst || !has)
        begin
            expect_write(enc_code_slot, enc_run_code, 1'b1, enc_next_pos, enc_dropped);
            enc_next_pos  = 1;
            enc_code_slot = 0;
            enc_run_code  = 1;
            enc_taken     = 0;
            enc_dropped   = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Write request checker: sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : write_check
        wr_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected write request: tdata %08h tlast %0b",
                             m_tdata, m_tlast);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[10:0] !== want.addr || m_tdata[18:11] !== want.wbyte ||
                    m_tlast !== want.done || m_tdata[29:19] !== want.len ||
                    m_tdata[30] !== want.ovf || m_tdata[31] !== 1'b0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("write request differs: exp addr %0d byte %02h done %0b %s",
                                 want.addr, want.wbyte, want.done, "");
                        $display("  exp len %0d ovf %0b", want.len, want.ovf);
                        $display("  got addr %0d byte %02h done %0b len %0d ovf %0b pad %0b",
                                 m_tdata[10:0], m_tdata[18:11], m_tlast, m_tdata[29:19],
                                 m_tdata[30], m_tdata[31]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Write sink: own ready pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : write_sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        int unsigned tick;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        tick      = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left == 0 && sink_hold_len != 0)
            begin
                hold_left     = sink_hold_len;
                sink_hold_len = 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(4, 80);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (mode == 0)
                m_tready <= 1'b1;                       // no stalls at all
            else if (mode == 1)
                m_tready <= 1'($urandom_range(0, 1));   // coin flip
            else
                m_tready <= ((tick % 3) == 0);          // ready only when tick is a multiple of three
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one request; bursts of random length with random idle gaps.
    task automatic send_item(input logic has, input logic [7:0] dbyte, input logic lst);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);              // garbage while idle
                s_tuser  <= 1'($urandom_range(0, 1));
                s_tlast  <= 1'($urandom_range(0, 1));
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= dbyte;
        s_tuser  <= has;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        encode_item(has, dbyte, lst);
    endtask

    function automatic logic [7:0] rand_byte(input int unsigned zero_pct);
        if ($urandom_range(0, 99) < zero_pct)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // One message of n_bytes raw bytes; an empty one always ends on a marker.
    task automatic send_message(input int unsigned n_bytes, input int unsigned zero_pct,
                                input msg_end_t how);
        logic lst;
        for (int unsigned i = 0; i < n_bytes; i++)
        begin
            lst = (how == END_ON_LAST) && (i == n_bytes - 1);
            send_item(1'b1, rand_byte(zero_pct), lst);
        end
        if (how == END_ON_MARKER || n_bytes == 0)
            send_item(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Sender pause: the request is withdrawn and nothing more is offered
    // until every write has come back.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty messages, single bytes, byte extremes, zero runs, end markers.
    task automatic test_directed_cases();
        send_item(1'b0, 8'hA5, 1'b0);   // empty message, marker ignores data
        send_item(1'b0, 8'h00, 1'b1);   // empty message, marker with last
        send_item(1'b1, 8'h00, 1'b1);   // lone zero byte
        send_item(1'b1, 8'hFF, 1'b1);   // lone 0xff byte
        send_item(1'b1, 8'h01, 1'b0);
        send_item(1'b1, 8'h80, 1'b0);
        send_item(1'b1, 8'h7F, 1'b0);
        send_item(1'b1, 8'hFE, 1'b1);
        send_item(1'b1, 8'h00, 1'b0);   // back-to-back zeros
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b1, 8'h11, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h22, 1'b0);
        send_item(1'b0, 8'h5A, 1'b0);   // marker closes a non-empty message
        send_item(1'b1, 8'h33, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1);
        wait_drain();
    endtask

    // A run of 254 nonzero bytes forces a 0xff code write-back; the message
    // ends on the same request, so that one request causes three writes.
    task automatic test_full_runs();
        send_message(254, 0, END_ON_LAST);
        wait_drain();
    endtask

    // Long sink hold-off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        sink_hold_len = 300;
        for (int unsigned m = 0; m < 12; m++)
            send_message($urandom_range(1, 5), 30,
                         ($urandom_range(0, 3) == 0) ? END_ON_MARKER : END_ON_LAST);
        wait_drain();
    endtask

    // Random well-formed messages, mostly short.
    task automatic test_random_messages();
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n_bytes;
        msg_end_t    how;
        stop_at = items_sent + 150;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                n_bytes = $urandom_range(0, 12);
            else
                n_bytes = $urandom_range(13, 60);
            how = ($urandom_range(0, 4) == 0) ? END_ON_MARKER : END_ON_LAST;
            send_message(n_bytes, $urandom_range(0, 40), how);
            if ($urandom_range(0, 9) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_full_runs();
        test_backpressure();
        test_random_messages();

        // Let stray requests surface past the pipeline latency.
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drain();
        repeat (20)
            @(posedge clk);

        if (fail_count == 0 && pending_writes.size() == 0)
            $display("cobs_frame_encoder: match");
        else
            $display("cobs_frame_encoder: mismatch");
        $finish;
    end

endmodule
